### rtl/assert_macros.svh
// ============================================================================
// Assertion macros
// Concurrent assertion wrappers shared by the relocation engine RTL.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset
`define ASSERT_ON(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Expression must never be true outside reset
`define ASSERT_NEVER(name, clk, rst_n, expr, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_ON(name, clk, rst_n, prop, msg)
`define ASSERT_NEVER(name, clk, rst_n, expr, msg)
`endif

`endif

### rtl/elfrel_pkg.sv
// ============================================================================
// elfrel_pkg
// Types, codes and sizes shared by the ELF64 RELA relocation engine.
// ============================================================================
`default_nettype none

package elfrel_pkg;

  // Table sizes
  localparam int SEG_SLOTS   = 8;
  localparam int SLOT_W      = $clog2(SEG_SLOTS);
  localparam int SYM_ENTRIES = 4096;
  localparam int SYM_IDX_W   = $clog2(SYM_ENTRIES);
  localparam int SYM_CNT_W   = 13;

  // Front to back queue, depth must be a power of two
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Stream widths
  localparam int IN_DATA_W  = 528;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 128;
  localparam int OUT_USER_W = 4;

  // Machines and relocation types
  localparam logic [15:0] MACH_X86_64      = 16'd62;
  localparam logic [15:0] MACH_AARCH64     = 16'd183;
  localparam logic [31:0] TYPE_AA_ABS64    = 32'd257;
  localparam logic [31:0] TYPE_AA_RELATIVE = 32'd1027;
  localparam logic [31:0] TYPE_X86_64      = 32'd1;
  localparam logic [31:0] TYPE_X86_RELATIVE = 32'd8;

  // Item opcodes
  typedef enum logic [1:0] {
    OP_LOAD_SEG = 2'd0,
    OP_LOAD_SYM = 2'd1,
    OP_APPLY    = 2'd2
  } op_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_MACHINE = 2'd0,
    CFG_IMAGE   = 2'd1,
    CFG_SYMCNT  = 2'd2
  } cfg_reg_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_WRITTEN  = 3'd0,
    ST_UNKNOWN  = 3'd1,
    ST_BADSYM   = 3'd2,
    ST_UNMAPPED = 3'd3,
    ST_BEYOND   = 3'd4,
    ST_LOADED   = 3'd5
  } status_e;

  // Command kinds after classification
  typedef enum logic [2:0] {
    CMD_SEG      = 3'd0,
    CMD_SYM      = 3'd1,
    CMD_DONE     = 3'd2,
    CMD_BAD_TYPE = 3'd3,
    CMD_BAD_SYM  = 3'd4,
    CMD_REL      = 3'd5,
    CMD_ABS      = 3'd6
  } cmd_e;

  typedef struct packed {
    logic [15:0]          machine_code;
    logic [30:0]          image_size;
    logic [SYM_CNT_W-1:0] symbol_count;
  } cfg_t;

  // One classified item; addr/arg carry segment virtual address and file offset for
  // segment loads, target address and addend for relocations
  typedef struct packed {
    cmd_e                 kind;
    logic [SLOT_W-1:0]    slot;
    logic [63:0]          addr;
    logic [63:0]          arg;
    logic [63:0]          fsize;
    logic [63:0]          msize;
    logic [SYM_IDX_W-1:0] sym_idx;
    logic [63:0]          sym_val;
  } cmd_t;

endpackage

`default_nettype wire

### rtl/elf_rela_relocation_engine_unit.sv
// ============================================================================
// elf_rela_relocation_engine_unit
// ELF64 RELA relocation engine: segment and symbol table loads, relocation
// resolution and translation into image write requests.
// ============================================================================
// Takes one item per clock and returns one result per item, in order. An
// item passes a classifier, a two-entry command queue, one execution stage
// (eight parallel segment comparators and the symbol memory read) and the
// output register, whose valid bit drives m_axis_tvalid. One item per
// cycle is sustained, with the output side ready, because
// every part takes a new command each cycle: all slots are compared at once,
// and the 4096 x 64 symbol memory has a separate write port and a registered
// read port, so each item costs one read. When the output is held off, the
// output register and the execution stage fill, then the queue, and
// s_axis_tready drops once the queue holds two commands. Symbol entries have
// no reset; the segment table has a valid bit per slot. The configuration
// port is always ready; registers must be written only while no item is in
// flight.
`default_nettype none

`include "assert_macros.svh"

module elf_rela_relocation_engine_unit import elfrel_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_index_i,
  input  logic [30:0]           cfg_data_i,
  // Input items
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // tdata: slot, seg_vaddr, seg_file_offset, seg_file_size, seg_mem_size,
  //        sym_index, sym_value, rel_target_vaddr, rel_type, rel_symbol,
  //        rel_addend, one zero pad bit
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: op
  input  logic [IN_USER_W-1:0]  s_axis_tuser,
  // Result items
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // tdata: write_offset, write_value
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // tuser: write_valid, status
  output logic [OUT_USER_W-1:0] m_axis_tuser
);

  cfg_t cfg_q;
  logic q_push, q_full, q_pop, q_valid;
  cmd_t q_cmd, q_head;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_MACHINE: cfg_q.machine_code <= cfg_data_i[15:0];
        CFG_IMAGE:   cfg_q.image_size   <= cfg_data_i;
        CFG_SYMCNT:  cfg_q.symbol_count <= cfg_data_i[SYM_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  elfrel_front u_front (
    .cfg_i     (cfg_q),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_data_i  (s_axis_tdata),
    .s_user_i  (s_axis_tuser),
    .q_full_i  (q_full),
    .push_o    (q_push),
    .cmd_o     (q_cmd)
  );

  elfrel_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .head_o  (q_head)
  );

  elfrel_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (q_valid),
    .q_head_i  (q_head),
    .pop_o     (q_pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata),
    .m_user_o  (m_axis_tuser)
  );

  // A write request and a written status always go together
  `ASSERT_ON(a_write_status, clk_i, rst_ni, m_axis_tvalid |-> (m_axis_tuser[0] == (m_axis_tuser[3:1] == ST_WRITTEN)), "write flag and status disagree")
  // Results without a write carry zero offset and value
  `ASSERT_NEVER(a_idle_payload, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser[0] && (m_axis_tdata != '0), "non-write result has payload")
  // Queue never pops when empty
  `ASSERT_NEVER(a_queue_underflow, clk_i, rst_ni, q_pop && !q_valid, "queue popped while empty")

endmodule

`default_nettype wire

### rtl/elfrel_ram.sv
// ============================================================================
// elfrel_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ============================================================================
`default_nettype none

module elfrel_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/elfrel_front.sv
// ============================================================================
// elfrel_front
// Unpacks input items and classifies them into queue commands.
// ============================================================================
`default_nettype none

module elfrel_front import elfrel_pkg::*; (
  input  cfg_t                 cfg_i,
  input  logic                 s_valid_i,
  output logic                 s_ready_o,
  input  logic [IN_DATA_W-1:0] s_data_i,
  input  logic [IN_USER_W-1:0] s_user_i,
  input  logic                 q_full_i,
  output logic                 push_o,
  output cmd_t                 cmd_o
);

  logic [SLOT_W-1:0]    slot;
  logic [63:0]          seg_vaddr, seg_file_offset, seg_file_size, seg_mem_size;
  logic [SYM_IDX_W-1:0] sym_index;
  logic [63:0]          sym_value, rel_target_vaddr, rel_addend;
  logic [31:0]          rel_type, rel_symbol;
  logic                 is_rel, is_abs, bad_sym;
  logic [SYM_CNT_W-1:0] sym_limit;

  // Field unpack, lowest field first
  assign slot             = s_data_i[2:0];
  assign seg_vaddr        = s_data_i[66:3];
  assign seg_file_offset  = s_data_i[130:67];
  assign seg_file_size    = s_data_i[194:131];
  assign seg_mem_size     = s_data_i[258:195];
  assign sym_index        = s_data_i[270:259];
  assign sym_value        = s_data_i[334:271];
  assign rel_target_vaddr = s_data_i[398:335];
  assign rel_type         = s_data_i[430:399];
  assign rel_symbol       = s_data_i[462:431];
  assign rel_addend       = s_data_i[526:463];

  // Type resolution for the configured machine
  assign is_rel = ((cfg_i.machine_code == MACH_AARCH64) && (rel_type == TYPE_AA_RELATIVE)) ||
                  ((cfg_i.machine_code == MACH_X86_64) && (rel_type == TYPE_X86_RELATIVE));
  assign is_abs = ((cfg_i.machine_code == MACH_AARCH64) && (rel_type == TYPE_AA_ABS64)) ||
                  ((cfg_i.machine_code == MACH_X86_64) && (rel_type == TYPE_X86_64));

  // Symbol bound is the smaller of the count and the table size
  assign sym_limit = (cfg_i.symbol_count > SYM_CNT_W'(SYM_ENTRIES)) ?
                     SYM_CNT_W'(SYM_ENTRIES) : cfg_i.symbol_count;
  assign bad_sym   = (|rel_symbol[31:SYM_CNT_W]) ||
                     (rel_symbol[SYM_CNT_W-1:0] >= sym_limit);

  // Build the command
  always_comb begin
    cmd_o.slot    = slot;
    cmd_o.fsize   = seg_file_size;
    cmd_o.msize   = seg_mem_size;
    cmd_o.sym_val = sym_value;
    cmd_o.addr    = rel_target_vaddr;
    cmd_o.arg     = rel_addend;
    cmd_o.sym_idx = rel_symbol[SYM_IDX_W-1:0];
    unique case (op_e'(s_user_i))
      OP_LOAD_SEG: begin
        cmd_o.kind = CMD_SEG;
        cmd_o.addr = seg_vaddr;
        cmd_o.arg  = seg_file_offset;
      end
      OP_LOAD_SYM: begin
        cmd_o.kind    = CMD_SYM;
        cmd_o.sym_idx = sym_index;
      end
      OP_APPLY: begin
        if (is_rel) begin
          cmd_o.kind = CMD_REL;
        end else if (!is_abs) begin
          cmd_o.kind = CMD_BAD_TYPE;
        end else if (bad_sym) begin
          cmd_o.kind = CMD_BAD_SYM;
        end else begin
          cmd_o.kind = CMD_ABS;
        end
      end
      default: cmd_o.kind = CMD_DONE;
    endcase
  end

  assign s_ready_o = !q_full_i;
  assign push_o    = s_valid_i && !q_full_i;

endmodule

`default_nettype wire

### rtl/elfrel_queue.sv
// ============================================================================
// elfrel_queue
// Short command queue between the classifier and the execution pipeline.
// ============================================================================
`default_nettype none

module elfrel_queue import elfrel_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t head_o
);

  cmd_t              entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = entry_q[rd_ptr_q];

endmodule

`default_nettype wire

### rtl/elfrel_back.sv
// ============================================================================
// elfrel_back
// Executes commands: table loads, segment translation, symbol read,
// value and offset sums, image bound check and the output register.
// ============================================================================
`default_nettype none

module elfrel_back import elfrel_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_t                  cfg_i,
  input  logic                  q_valid_i,
  input  cmd_t                  q_head_i,
  output logic                  pop_o,
  output logic                  m_valid_o,
  input  logic                  m_ready_i,
  output logic [OUT_DATA_W-1:0] m_data_o,
  output logic [OUT_USER_W-1:0] m_user_o
);

  // Segment table
  logic [SEG_SLOTS-1:0] seg_valid_q;
  logic [63:0]          seg_vaddr_q [SEG_SLOTS];
  logic [63:0]          seg_base_q  [SEG_SLOTS];
  logic [63:0]          seg_flen_q  [SEG_SLOTS];
  logic [63:0]          seg_mlen_q  [SEG_SLOTS];

  // Per-slot translation
  logic [SEG_SLOTS-1:0] hit, in_file;
  logic [63:0]          delta [SEG_SLOTS];
  logic                 any_hit, sel_in_file;
  logic [SLOT_W-1:0]    sel;

  // Execution stage
  logic        b_valid_q;
  cmd_e        b_kind_q;
  logic        b_mapped_q;
  logic [63:0] b_delta_q, b_base_q, b_addend_q;
  logic [63:0] sym_rdata;

  // Output stage
  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic [OUT_USER_W-1:0] out_user_q;

  logic        out_adv, b_free;
  logic [63:0] wr_value, wr_offset;
  logic [31:0] wr_end;
  logic        beyond;
  status_e     status;
  logic        wr_valid;

  assign out_adv = !out_valid_q || m_ready_i;
  assign b_free  = !b_valid_q || out_adv;
  assign pop_o   = q_valid_i && b_free;

  // Segment table write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_valid_q <= '0;
    end else if (pop_o && (q_head_i.kind == CMD_SEG)) begin
      seg_valid_q[q_head_i.slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && (q_head_i.kind == CMD_SEG)) begin
      seg_vaddr_q[q_head_i.slot] <= q_head_i.addr;
      seg_base_q[q_head_i.slot]  <= q_head_i.arg;
      seg_flen_q[q_head_i.slot]  <= q_head_i.fsize;
      seg_mlen_q[q_head_i.slot]  <= q_head_i.msize;
    end
  end

  // Parallel range compare, one per slot
  always_comb begin
    for (int i = 0; i < SEG_SLOTS; i++) begin
      delta[i]   = q_head_i.addr - seg_vaddr_q[i];
      hit[i]     = seg_valid_q[i] && (q_head_i.addr >= seg_vaddr_q[i]) &&
                   (delta[i] < seg_mlen_q[i]);
      in_file[i] = (delta[i] < seg_flen_q[i]);
    end
  end

  // Lowest hitting slot wins
  always_comb begin
    sel = '0;
    for (int i = SEG_SLOTS - 1; i >= 0; i--) begin
      if (hit[i]) begin
        sel = SLOT_W'(i);
      end
    end
  end

  assign any_hit     = |hit;
  assign sel_in_file = in_file[sel];

  // Symbol value memory
  elfrel_ram #(
    .WIDTH (64),
    .DEPTH (SYM_ENTRIES)
  ) u_sym_ram (
    .clk_i   (clk_i),
    .we_i    (pop_o && (q_head_i.kind == CMD_SYM)),
    .waddr_i (q_head_i.sym_idx),
    .wdata_i (q_head_i.sym_val),
    .re_i    (pop_o),
    .raddr_i (q_head_i.sym_idx),
    .rdata_o (sym_rdata)
  );

  // Execution stage registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_free) begin
      b_valid_q <= q_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      b_kind_q   <= q_head_i.kind;
      b_mapped_q <= any_hit && sel_in_file;
      b_delta_q  <= delta[sel];
      b_base_q   <= seg_base_q[sel];
      b_addend_q <= q_head_i.arg;
    end
  end

  // Value, file offset and image bound
  assign wr_value  = ((b_kind_q == CMD_ABS) ? sym_rdata : 64'd0) + b_addend_q;
  assign wr_offset = b_base_q + b_delta_q;
  assign wr_end    = {1'b0, wr_offset[30:0]} + 32'd8;
  assign beyond    = (|wr_offset[63:31]) || (wr_end > {1'b0, cfg_i.image_size});

  always_comb begin
    wr_valid = 1'b0;
    case (b_kind_q) inside
      CMD_BAD_TYPE: status = ST_UNKNOWN;
      CMD_BAD_SYM:  status = ST_BADSYM;
      CMD_REL, CMD_ABS: begin
        if (!b_mapped_q) begin
          status = ST_UNMAPPED;
        end else if (beyond) begin
          status = ST_BEYOND;
        end else begin
          status   = ST_WRITTEN;
          wr_valid = 1'b1;
        end
      end
      default: status = ST_LOADED;
    endcase
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && b_valid_q) begin
      out_data_q <= wr_valid ? {wr_value, wr_offset} : '0;
      out_user_q <= {status, wr_valid};
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_data_o  = out_data_q;
  assign m_user_o  = out_user_q;

endmodule

`default_nettype wire
